>>> rtl/egcd_pkg.sv
// shared types and constants for the binary extended gcd unit
`timescale 1ns / 1ps

package egcd_pkg;

	localparam int OPERAND_BITS = 31;
	localparam int COEF_W       = OPERAND_BITS + 3;
	localparam int COEF_EXT     = COEF_W - OPERAND_BITS;
	localparam int COEF_OUT_W   = 32;
	localparam int SHIFT_W      = $clog2(OPERAND_BITS);

	typedef logic [OPERAND_BITS-1:0] opnd_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [COEF_OUT_W-1:0] coef_out_t;
	typedef logic [SHIFT_W-1:0] shift_t;

	typedef enum logic {
		ALU_HALVE,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		opnd_t   m1;
		coef_t   p1;
		coef_t   q1;
		opnd_t   m2;
		coef_t   p2;
		coef_t   q2;
		opnd_t   x;
		opnd_t   y;
	} alu_req_t;

	typedef struct packed {
		opnd_t m;
		coef_t p;
		coef_t q;
	} alu_rsp_t;

	typedef struct packed {
		opnd_t operand_a;
		opnd_t operand_b;
	} in_word_t;

	typedef struct packed {
		opnd_t     gcd_value;
		coef_out_t coef_larger;
		coef_out_t coef_smaller;
		logic      input_error;
	} out_word_t;

	function automatic coef_t zext_coef(input opnd_t val);
		coef_t res;
		res = coef_t'({{COEF_EXT{1'b0}}, val});
		return res;
	endfunction

	function automatic coef_out_t coef_out(input coef_t c);
		logic signed [COEF_W+COEF_OUT_W-1:0] wide;
		wide = c;
		return wide[COEF_OUT_W-1:0];
	endfunction

endpackage

>>> rtl/egcd_alu.sv
// shared halve and subtract unit for the magnitude and coefficient pair
`timescale 1ns / 1ps

module egcd_alu (
	input  egcd_pkg::alu_req_t req,
	output egcd_pkg::alu_rsp_t rsp
);

	egcd_pkg::coef_t sum_p;
	egcd_pkg::coef_t sum_q;
	logic            fix;

	always_comb begin
		fix   = req.p1[0] | req.q1[0];
		sum_p = req.p1;
		sum_q = req.q1;
		rsp   = '0;
		case (req.op)
			egcd_pkg::ALU_HALVE: begin
				if (fix) begin
					sum_p = req.p1 + egcd_pkg::zext_coef(req.y);
					sum_q = req.q1 - egcd_pkg::zext_coef(req.x);
				end
				rsp.m = req.m1 >> 1;
				rsp.p = sum_p >>> 1;
				rsp.q = sum_q >>> 1;
			end
			egcd_pkg::ALU_SUB: begin
				rsp.m = req.m1 - req.m2;
				rsp.p = req.p1 - req.p2;
				rsp.q = req.q1 - req.q2;
			end
			default: begin
				rsp = '0;
			end
		endcase
	end

endmodule

>>> rtl/extended_binary_gcd.sv
// top level of the binary extended gcd unit: sequencer and operand registers
// an operand of zero gives an error result straight from idle; otherwise the sequencer strips
//   common factors of two, runs halving and subtract steps, then shifts the gcd back up
// a new word is taken only while busy is low, busy stays high until the result strobe
// the result is shown for one cycle with done high and cannot be stalled
// reset clears the sequencer and the strobe, data registers are not reset
`timescale 1ns / 1ps

module extended_binary_gcd (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  egcd_pkg::in_word_t   operands,
	output logic                 busy,
	output logic                 done,
	output egcd_pkg::out_word_t  result
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_STRIP,
		S_LOOP,
		S_SCALE
	} state_t;

	state_t               state_q;
	egcd_pkg::opnd_t      x_q;
	egcd_pkg::opnd_t      y_q;
	egcd_pkg::opnd_t      u_q;
	egcd_pkg::opnd_t      v_q;
	egcd_pkg::coef_t      a_q;
	egcd_pkg::coef_t      b_q;
	egcd_pkg::coef_t      c_q;
	egcd_pkg::coef_t      d_q;
	egcd_pkg::shift_t     shift_q;
	egcd_pkg::alu_req_t   alu_req;
	egcd_pkg::alu_rsp_t   alu_rsp;
	logic                 u_ge_v;
	logic                 accept;

	assign accept = start & ~busy;
	assign u_ge_v = u_q >= v_q;

	// operand selection for the shared unit
	always_comb begin
		alu_req    = '0;
		alu_req.x  = x_q;
		alu_req.y  = y_q;
		alu_req.op = egcd_pkg::ALU_SUB;
		if (!u_q[0]) begin
			alu_req.op = egcd_pkg::ALU_HALVE;
			alu_req.m1 = u_q;
			alu_req.p1 = a_q;
			alu_req.q1 = b_q;
		end else if (!v_q[0]) begin
			alu_req.op = egcd_pkg::ALU_HALVE;
			alu_req.m1 = v_q;
			alu_req.p1 = c_q;
			alu_req.q1 = d_q;
		end else if (u_ge_v) begin
			alu_req.m1 = u_q;
			alu_req.p1 = a_q;
			alu_req.q1 = b_q;
			alu_req.m2 = v_q;
			alu_req.p2 = c_q;
			alu_req.q2 = d_q;
		end else begin
			alu_req.m1 = v_q;
			alu_req.p1 = c_q;
			alu_req.q1 = d_q;
			alu_req.m2 = u_q;
			alu_req.p2 = a_q;
			alu_req.q2 = b_q;
		end
	end

	egcd_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy    <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (operands.operand_a == '0 || operands.operand_b == '0) begin
							result.gcd_value    <= '0;
							result.coef_larger  <= '0;
							result.coef_smaller <= '0;
							result.input_error  <= 1'b1;
							done <= 1'b1;
						end else begin
							if (operands.operand_a < operands.operand_b) begin
								x_q <= operands.operand_b;
								y_q <= operands.operand_a;
							end else begin
								x_q <= operands.operand_a;
								y_q <= operands.operand_b;
							end
							shift_q <= '0;
							busy    <= 1'b1;
							state_q <= S_STRIP;
						end
					end
				end
				S_STRIP: begin
					if (!(x_q[0] | y_q[0])) begin
						x_q     <= x_q >> 1;
						y_q     <= y_q >> 1;
						shift_q <= shift_q + 1'b1;
					end else begin
						u_q     <= x_q;
						v_q     <= y_q;
						a_q     <= egcd_pkg::coef_t'(1);
						b_q     <= '0;
						c_q     <= '0;
						d_q     <= egcd_pkg::coef_t'(1);
						state_q <= S_LOOP;
					end
				end
				S_LOOP: begin
					if (u_q == '0) begin
						state_q <= S_SCALE;
					end else if (!u_q[0] || (v_q[0] && u_ge_v)) begin
						u_q <= alu_rsp.m;
						a_q <= alu_rsp.p;
						b_q <= alu_rsp.q;
					end else begin
						v_q <= alu_rsp.m;
						c_q <= alu_rsp.p;
						d_q <= alu_rsp.q;
					end
				end
				S_SCALE: begin
					if (shift_q != '0) begin
						v_q     <= v_q << 1;
						shift_q <= shift_q - 1'b1;
					end else begin
						result.gcd_value    <= v_q;
						result.coef_larger  <= egcd_pkg::coef_out(c_q);
						result.coef_smaller <= egcd_pkg::coef_out(d_q);
						result.input_error  <= 1'b0;
						done    <= 1'b1;
						busy    <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy    <= 1'b0;
				end
			endcase
		end
	end

endmodule
